[design/hst_pkg.sv]
// Package for the handle slot table: sizes, operation and status codes,
// controller states, datapath commands and the control/status structs.
// No dependencies.
package hst_pkg;

	localparam int DEPTH    = 64;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = IDX_W + 1;
	localparam int HANDLE_W = 32;
	localparam int CFG_AW   = 5;
	localparam int DATA_W   = 32;

	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [HANDLE_W-1:0] handle_t;

	typedef enum logic [2:0] {
		K_ADD, K_GET, K_GET_LAST, K_FIND, K_DEL_IDX, K_DEL_HANDLE, K_CLEAR, K_MARK
	} kind_t;

	typedef enum logic [1:0] {ST_OK, ST_NOTFOUND, ST_NULL, ST_FULL} status_t;

	localparam logic [2:0] REG_REUSE      = 3'd0;
	localparam logic [2:0] REG_COMPACT    = 3'd1;
	localparam logic [2:0] REG_SWAP       = 3'd2;
	localparam logic [2:0] REG_STATIONARY = 3'd3;
	localparam logic [2:0] REG_CONSERVE   = 3'd4;
	localparam logic [2:0] REG_KEEP       = 3'd5;

	typedef struct packed {
		logic reuse;
		logic compact;
		logic swap;
		logic stationary;
		logic conserve;
		logic keep;
	} cfg_t;

	typedef enum logic [1:0] {RM_CLR, RM_SHIFT, RM_SWAP} rm_mode_t;

	typedef enum logic [5:0] {
		C_NONE, C_LOAD, C_SET_NULL, C_SET_NF, C_PTR_HINT, C_PTR_INC, C_PTR_DEC,
		C_PTR_ZERO, C_PTR_EXT, C_HINT_PTR, C_ADD_REUSE, C_ADD_APPEND, C_ADD_FULL,
		C_RD_IDX, C_GET_RES, C_RD_PTRM1, C_GL_RES, C_RD_PTR, C_FIND_RES, C_POS_PTR,
		C_POS_IDX, C_RM_CLEAR, C_SHIFT_INIT, C_SH_RD, C_SH_WR, C_SH_END, C_RD_LAST,
		C_SWAP_WR, C_EXT_DEC, C_RM_HINT, C_CLEAR, C_MARK
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_ADD_SCAN, S_ADD_TAIL, S_GET_WAIT, S_GL_SCAN, S_GL_WAIT,
		S_FD_RD, S_FD_CMP, S_RM_START, S_SH_RD, S_SH_WR, S_SW_WR, S_RM_TRIM, S_RESP
	} state_t;

	typedef struct packed {
		kind_t    kind;
		logic     hnull;
		logic     reuse_ok;
		logic     ptr_lt_ext;
		logic     ptr_valid;
		logic     ptr_nz;
		logic     ptrm1_valid;
		logic     idx_ok;
		logic     idx_valid;
		logic     ext_full;
		logic     any_live;
		logic     hit;
		rm_mode_t rm_mode;
		logic     trim_more;
	} stat_t;

endpackage

[design/hst_ctrl.sv]
// Controller state machine of the handle slot table.
// Issues one datapath command per cycle; uses hst_pkg.
module hst_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  hst_pkg::stat_t st,
	output hst_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	hst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
		hst_pkg::S_IDLE: begin
			if (start) state_d = hst_pkg::S_DISPATCH;
		end
		hst_pkg::S_DISPATCH: begin
			case (st.kind)
			hst_pkg::K_ADD: begin
				if (st.hnull) state_d = hst_pkg::S_RESP;
				else if (st.reuse_ok) state_d = hst_pkg::S_ADD_SCAN;
				else state_d = hst_pkg::S_ADD_TAIL;
			end
			hst_pkg::K_GET: begin
				state_d = st.idx_ok ? hst_pkg::S_GET_WAIT : hst_pkg::S_RESP;
			end
			hst_pkg::K_GET_LAST: begin
				state_d = st.any_live ? hst_pkg::S_GL_SCAN : hst_pkg::S_RESP;
			end
			hst_pkg::K_FIND, hst_pkg::K_DEL_HANDLE: begin
				state_d = st.hnull ? hst_pkg::S_RESP : hst_pkg::S_FD_RD;
			end
			hst_pkg::K_DEL_IDX: begin
				state_d = (st.idx_ok && st.idx_valid) ? hst_pkg::S_RM_START : hst_pkg::S_RESP;
			end
			default: state_d = hst_pkg::S_RESP;
			endcase
		end
		hst_pkg::S_ADD_SCAN: begin
			if (!(st.ptr_lt_ext && st.ptr_valid)) begin
				state_d = st.ptr_lt_ext ? hst_pkg::S_RESP : hst_pkg::S_ADD_TAIL;
			end
		end
		hst_pkg::S_ADD_TAIL: state_d = hst_pkg::S_RESP;
		hst_pkg::S_GET_WAIT: state_d = hst_pkg::S_RESP;
		hst_pkg::S_GL_SCAN: begin
			if (!st.ptr_nz) state_d = hst_pkg::S_RESP;
			else if (st.ptrm1_valid) state_d = hst_pkg::S_GL_WAIT;
		end
		hst_pkg::S_GL_WAIT: state_d = hst_pkg::S_RESP;
		hst_pkg::S_FD_RD: begin
			state_d = st.ptr_lt_ext ? hst_pkg::S_FD_CMP : hst_pkg::S_RESP;
		end
		hst_pkg::S_FD_CMP: begin
			if (!st.hit) state_d = hst_pkg::S_FD_RD;
			else if (st.kind == hst_pkg::K_FIND) state_d = hst_pkg::S_RESP;
			else state_d = hst_pkg::S_RM_START;
		end
		hst_pkg::S_RM_START: begin
			case (st.rm_mode)
			hst_pkg::RM_SHIFT: state_d = hst_pkg::S_SH_RD;
			hst_pkg::RM_SWAP:  state_d = hst_pkg::S_SW_WR;
			default:           state_d = hst_pkg::S_RM_TRIM;
			endcase
		end
		hst_pkg::S_SH_RD: begin
			state_d = st.ptr_lt_ext ? hst_pkg::S_SH_WR : hst_pkg::S_RM_TRIM;
		end
		hst_pkg::S_SH_WR: state_d = hst_pkg::S_SH_RD;
		hst_pkg::S_SW_WR: state_d = hst_pkg::S_RM_TRIM;
		hst_pkg::S_RM_TRIM: begin
			if (!st.trim_more) state_d = hst_pkg::S_RESP;
		end
		hst_pkg::S_RESP: state_d = hst_pkg::S_IDLE;
		default: state_d = hst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = hst_pkg::C_NONE;
		busy = (state_q != hst_pkg::S_IDLE);
		done = (state_q == hst_pkg::S_RESP);
		case (state_q)
		hst_pkg::S_IDLE: begin
			if (start) cmd = hst_pkg::C_LOAD;
		end
		hst_pkg::S_DISPATCH: begin
			case (st.kind)
			hst_pkg::K_ADD: begin
				if (st.hnull) cmd = hst_pkg::C_SET_NULL;
				else if (st.reuse_ok) cmd = hst_pkg::C_PTR_HINT;
			end
			hst_pkg::K_GET: begin
				cmd = st.idx_ok ? hst_pkg::C_RD_IDX : hst_pkg::C_SET_NF;
			end
			hst_pkg::K_GET_LAST: begin
				cmd = st.any_live ? hst_pkg::C_PTR_EXT : hst_pkg::C_SET_NF;
			end
			hst_pkg::K_FIND, hst_pkg::K_DEL_HANDLE: begin
				cmd = st.hnull ? hst_pkg::C_SET_NULL : hst_pkg::C_PTR_ZERO;
			end
			hst_pkg::K_DEL_IDX: begin
				cmd = (st.idx_ok && st.idx_valid) ? hst_pkg::C_POS_IDX : hst_pkg::C_SET_NF;
			end
			hst_pkg::K_CLEAR: cmd = hst_pkg::C_CLEAR;
			default:          cmd = hst_pkg::C_MARK;
			endcase
		end
		hst_pkg::S_ADD_SCAN: begin
			if (st.ptr_lt_ext && st.ptr_valid) cmd = hst_pkg::C_PTR_INC;
			else if (st.ptr_lt_ext) cmd = hst_pkg::C_ADD_REUSE;
			else cmd = hst_pkg::C_HINT_PTR;
		end
		hst_pkg::S_ADD_TAIL: begin
			cmd = st.ext_full ? hst_pkg::C_ADD_FULL : hst_pkg::C_ADD_APPEND;
		end
		hst_pkg::S_GET_WAIT: cmd = hst_pkg::C_GET_RES;
		hst_pkg::S_GL_SCAN: begin
			if (!st.ptr_nz) cmd = hst_pkg::C_SET_NF;
			else if (st.ptrm1_valid) cmd = hst_pkg::C_RD_PTRM1;
			else cmd = hst_pkg::C_PTR_DEC;
		end
		hst_pkg::S_GL_WAIT: cmd = hst_pkg::C_GL_RES;
		hst_pkg::S_FD_RD: begin
			cmd = st.ptr_lt_ext ? hst_pkg::C_RD_PTR : hst_pkg::C_SET_NF;
		end
		hst_pkg::S_FD_CMP: begin
			if (!st.hit) cmd = hst_pkg::C_PTR_INC;
			else if (st.kind == hst_pkg::K_FIND) cmd = hst_pkg::C_FIND_RES;
			else cmd = hst_pkg::C_POS_PTR;
		end
		hst_pkg::S_RM_START: begin
			case (st.rm_mode)
			hst_pkg::RM_SHIFT: cmd = hst_pkg::C_SHIFT_INIT;
			hst_pkg::RM_SWAP:  cmd = hst_pkg::C_RD_LAST;
			default:           cmd = hst_pkg::C_RM_CLEAR;
			endcase
		end
		hst_pkg::S_SH_RD: begin
			cmd = st.ptr_lt_ext ? hst_pkg::C_SH_RD : hst_pkg::C_SH_END;
		end
		hst_pkg::S_SH_WR: cmd = hst_pkg::C_SH_WR;
		hst_pkg::S_SW_WR: cmd = hst_pkg::C_SWAP_WR;
		hst_pkg::S_RM_TRIM: begin
			cmd = st.trim_more ? hst_pkg::C_EXT_DEC : hst_pkg::C_RM_HINT;
		end
		default: cmd = hst_pkg::C_NONE;
		endcase
	end

endmodule

[design/hst_dp.sv]
// Datapath of the handle slot table: slot memory, occupancy bits, extent,
// count, free hint, sorted mark and result registers. Uses hst_pkg.
module hst_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  hst_pkg::cmd_t    cmd,
	input  hst_pkg::cfg_t    cfg,
	input  hst_pkg::kind_t   kind,
	input  hst_pkg::idx_t    slot_index,
	input  hst_pkg::handle_t handle,
	output hst_pkg::stat_t   st,
	output hst_pkg::status_t status,
	output hst_pkg::idx_t    result_index,
	output hst_pkg::handle_t result_handle,
	output hst_pkg::cnt_t    live_count,
	output hst_pkg::cnt_t    used_extent
);

	hst_pkg::handle_t mem [hst_pkg::DEPTH];
	hst_pkg::handle_t rdata_q;
	logic             rvalid_q;
	logic [hst_pkg::DEPTH-1:0] valid_q;

	hst_pkg::kind_t   kind_q;
	hst_pkg::idx_t    idx_q, pos_q, rindex_q;
	hst_pkg::handle_t h_q, rhandle_q;
	hst_pkg::status_t status_q;
	hst_pkg::cnt_t    ext_q, cnt_q, hint_q, ptr_q;
	logic             sorted_q, hole_q;

	hst_pkg::cnt_t    ptrm1, extm1, ptrp1;
	logic             re, we;
	hst_pkg::idx_t    raddr, waddr;
	hst_pkg::handle_t wdata;

	assign ptrm1 = ptr_q - 1'b1;
	assign ptrp1 = ptr_q + 1'b1;
	assign extm1 = ext_q - 1'b1;

	always_comb begin
		st.kind        = kind_q;
		st.hnull       = (h_q == '0);
		st.reuse_ok    = (cfg.reuse || cfg.conserve) && !cfg.keep && (cnt_q < ext_q);
		st.ptr_lt_ext  = (ptr_q < ext_q);
		st.ptr_valid   = valid_q[ptr_q[hst_pkg::IDX_W-1:0]];
		st.ptr_nz      = (ptr_q != '0);
		st.ptrm1_valid = valid_q[ptrm1[hst_pkg::IDX_W-1:0]];
		st.idx_ok      = ({1'b0, idx_q} < ext_q);
		st.idx_valid   = valid_q[idx_q];
		st.ext_full    = (ext_q == hst_pkg::CNT_W'(hst_pkg::DEPTH));
		st.any_live    = (cnt_q != '0) && (ext_q != '0);
		st.hit         = rvalid_q && (rdata_q == h_q);
		st.trim_more   = cfg.conserve && (ext_q > {1'b0, pos_q})
			&& !valid_q[extm1[hst_pkg::IDX_W-1:0]];
		if (cfg.stationary) begin
			st.rm_mode = hst_pkg::RM_CLR;
		end else if (sorted_q || cfg.keep) begin
			st.rm_mode = cfg.compact ? hst_pkg::RM_SHIFT : hst_pkg::RM_CLR;
		end else if ((cfg.swap || cfg.compact) && ({1'b0, pos_q} != extm1)) begin
			st.rm_mode = hst_pkg::RM_SWAP;
		end else begin
			st.rm_mode = hst_pkg::RM_CLR;
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q[hst_pkg::IDX_W-1:0];
		we    = 1'b0;
		waddr = ptr_q[hst_pkg::IDX_W-1:0];
		wdata = h_q;
		case (cmd)
		hst_pkg::C_RD_IDX: begin
			re    = 1'b1;
			raddr = idx_q;
		end
		hst_pkg::C_RD_PTR: re = 1'b1;
		hst_pkg::C_RD_PTRM1: begin
			re    = 1'b1;
			raddr = ptrm1[hst_pkg::IDX_W-1:0];
		end
		hst_pkg::C_SH_RD: begin
			re    = 1'b1;
			raddr = ptrp1[hst_pkg::IDX_W-1:0];
		end
		hst_pkg::C_RD_LAST: begin
			re    = 1'b1;
			raddr = extm1[hst_pkg::IDX_W-1:0];
		end
		hst_pkg::C_ADD_REUSE: we = 1'b1;
		hst_pkg::C_ADD_APPEND: begin
			we    = 1'b1;
			waddr = ext_q[hst_pkg::IDX_W-1:0];
		end
		hst_pkg::C_SH_WR: begin
			we    = 1'b1;
			wdata = rdata_q;
		end
		hst_pkg::C_SWAP_WR: begin
			we    = 1'b1;
			waddr = pos_q;
			wdata = rdata_q;
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) begin
			rdata_q  <= mem[raddr];
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
		hst_pkg::C_LOAD: begin
			kind_q    <= kind;
			idx_q     <= slot_index;
			h_q       <= handle;
			status_q  <= hst_pkg::ST_OK;
			rindex_q  <= '0;
			rhandle_q <= '0;
		end
		hst_pkg::C_SET_NULL: status_q <= hst_pkg::ST_NULL;
		hst_pkg::C_SET_NF:   status_q <= hst_pkg::ST_NOTFOUND;
		hst_pkg::C_ADD_FULL: status_q <= hst_pkg::ST_FULL;
		hst_pkg::C_ADD_REUSE: rindex_q <= ptr_q[hst_pkg::IDX_W-1:0];
		hst_pkg::C_ADD_APPEND: rindex_q <= ext_q[hst_pkg::IDX_W-1:0];
		hst_pkg::C_GET_RES: begin
			rindex_q  <= idx_q;
			rhandle_q <= rvalid_q ? rdata_q : '0;
		end
		hst_pkg::C_GL_RES: begin
			rindex_q  <= ptrm1[hst_pkg::IDX_W-1:0];
			rhandle_q <= rvalid_q ? rdata_q : '0;
		end
		hst_pkg::C_FIND_RES: begin
			rindex_q  <= ptr_q[hst_pkg::IDX_W-1:0];
			rhandle_q <= h_q;
		end
		hst_pkg::C_POS_PTR: begin
			pos_q    <= ptr_q[hst_pkg::IDX_W-1:0];
			rindex_q <= ptr_q[hst_pkg::IDX_W-1:0];
		end
		hst_pkg::C_POS_IDX: begin
			pos_q    <= idx_q;
			rindex_q <= idx_q;
		end
		default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			ext_q    <= '0;
			cnt_q    <= '0;
			hint_q   <= '0;
			ptr_q    <= '0;
			sorted_q <= 1'b0;
			hole_q   <= 1'b0;
		end else begin
			case (cmd)
			hst_pkg::C_PTR_HINT: ptr_q <= hint_q;
			hst_pkg::C_PTR_INC:  ptr_q <= ptrp1;
			hst_pkg::C_PTR_DEC:  ptr_q <= ptrm1;
			hst_pkg::C_PTR_ZERO: ptr_q <= '0;
			hst_pkg::C_PTR_EXT:  ptr_q <= ext_q;
			hst_pkg::C_HINT_PTR: hint_q <= ptr_q;
			hst_pkg::C_ADD_REUSE: begin
				valid_q[ptr_q[hst_pkg::IDX_W-1:0]] <= 1'b1;
				hint_q   <= ptrp1;
				cnt_q    <= cnt_q + 1'b1;
				sorted_q <= 1'b0;
			end
			hst_pkg::C_ADD_APPEND: begin
				valid_q[ext_q[hst_pkg::IDX_W-1:0]] <= 1'b1;
				ext_q    <= ext_q + 1'b1;
				cnt_q    <= cnt_q + 1'b1;
				sorted_q <= 1'b0;
			end
			hst_pkg::C_ADD_FULL: sorted_q <= 1'b0;
			hst_pkg::C_RM_CLEAR: begin
				valid_q[pos_q] <= 1'b0;
				cnt_q  <= cnt_q - 1'b1;
				hole_q <= 1'b1;
				if ({1'b0, pos_q} == extm1) ext_q <= extm1;
			end
			hst_pkg::C_SHIFT_INIT: begin
				cnt_q  <= cnt_q - 1'b1;
				ext_q  <= extm1;
				ptr_q  <= {1'b0, pos_q};
				hole_q <= 1'b0;
			end
			hst_pkg::C_SH_WR: begin
				valid_q[ptr_q[hst_pkg::IDX_W-1:0]] <= rvalid_q;
				ptr_q <= ptrp1;
			end
			hst_pkg::C_SH_END: valid_q[ext_q[hst_pkg::IDX_W-1:0]] <= 1'b0;
			hst_pkg::C_SWAP_WR: begin
				valid_q[extm1[hst_pkg::IDX_W-1:0]] <= 1'b0;
				valid_q[pos_q] <= rvalid_q;
				ext_q    <= extm1;
				cnt_q    <= cnt_q - 1'b1;
				sorted_q <= 1'b0;
				hole_q   <= 1'b0;
			end
			hst_pkg::C_EXT_DEC: ext_q <= extm1;
			hst_pkg::C_RM_HINT: begin
				if (hole_q && ({1'b0, pos_q} < hint_q)) hint_q <= {1'b0, pos_q};
			end
			hst_pkg::C_CLEAR: begin
				valid_q <= '0;
				ext_q   <= '0;
				cnt_q   <= '0;
				hint_q  <= '0;
			end
			hst_pkg::C_MARK: sorted_q <= 1'b1;
			default: ;
			endcase
		end
	end

	assign status        = status_q;
	assign result_index  = rindex_q;
	assign result_handle = rhandle_q;
	assign live_count    = cnt_q;
	assign used_extent   = ext_q;

endmodule

[design/handle_slot_table.sv]
// Handle slot table: one operation per start, one result per done strobe.
// Clear, mark and rejected requests go from dispatch straight to the response
// state; get passes through a read wait state first. Find and delete by handle
// walk the slot memory one entry at a time through its read port, alternating a
// read state and a compare state, and a compacting delete shifts entries down one
// at a time, alternating a read state and a write state. A reusing add, get_last
// and the tail trim walk occupancy bits one slot per cycle. The result is shown
// while done is high, for one cycle only; the receiver must take it then. busy is
// high from dispatch until that cycle. Uses hst_pkg, hst_ctrl and hst_dp.
module handle_slot_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [hst_pkg::CFG_AW-1:0]   paddr,
	input  logic [hst_pkg::DATA_W-1:0]   pwdata,
	output logic [hst_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   kind,
	input  logic [hst_pkg::IDX_W-1:0]    slot_index,
	input  logic [hst_pkg::HANDLE_W-1:0] handle,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [hst_pkg::IDX_W-1:0]    result_index,
	output logic [hst_pkg::HANDLE_W-1:0] result_handle,
	output logic [hst_pkg::CNT_W-1:0]    live_count,
	output logic [hst_pkg::CNT_W-1:0]    used_extent
);

	hst_pkg::cfg_t    cfg_q;
	hst_pkg::cmd_t    cmd;
	hst_pkg::stat_t   st;
	hst_pkg::status_t status_w;
	logic [2:0]       reg_sel;
	logic             cfg_wr;
	logic             rd_bit;

	assign pready  = 1'b1;
	assign reg_sel = paddr[hst_pkg::CFG_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
			hst_pkg::REG_REUSE:      cfg_q.reuse      <= pwdata[0];
			hst_pkg::REG_COMPACT:    cfg_q.compact    <= pwdata[0];
			hst_pkg::REG_SWAP:       cfg_q.swap       <= pwdata[0];
			hst_pkg::REG_STATIONARY: cfg_q.stationary <= pwdata[0];
			hst_pkg::REG_CONSERVE:   cfg_q.conserve   <= pwdata[0];
			hst_pkg::REG_KEEP:       cfg_q.keep       <= pwdata[0];
			default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
		hst_pkg::REG_REUSE:      rd_bit = cfg_q.reuse;
		hst_pkg::REG_COMPACT:    rd_bit = cfg_q.compact;
		hst_pkg::REG_SWAP:       rd_bit = cfg_q.swap;
		hst_pkg::REG_STATIONARY: rd_bit = cfg_q.stationary;
		hst_pkg::REG_CONSERVE:   rd_bit = cfg_q.conserve;
		hst_pkg::REG_KEEP:       rd_bit = cfg_q.keep;
		default:                 rd_bit = 1'b0;
		endcase
	end

	assign prdata = {{(hst_pkg::DATA_W-1){1'b0}}, rd_bit};

	hst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	hst_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.kind          (hst_pkg::kind_t'(kind)),
		.slot_index    (slot_index),
		.handle        (handle),
		.st            (st),
		.status        (status_w),
		.result_index  (result_index),
		.result_handle (result_handle),
		.live_count    (live_count),
		.used_extent   (used_extent)
	);

	assign status = status_w;

endmodule
